/* rtl/psmt_pkg.sv */
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; every other file in rtl/ imports this package.
package psmt_pkg;

    // Default and reset values.
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int RESET_POS_X        = 512;
    localparam int RESET_POS_Y        = 384;
    localparam int MAX_X_RESET        = 1023;
    localparam int MAX_Y_RESET        = 767;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 16;
    localparam int DELTA_W = 9;

    // Bit positions inside the first byte of a packet.
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    // Configuration register indexes.
    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    // Position of the next byte within a packet.
    typedef enum logic [1:0] {
        IDX_FIRST  = 2'd0,
        IDX_SECOND = 2'd1,
        IDX_THIRD  = 2'd2
    } idx_t;

    // Decoder view of the byte being offered this cycle.
    typedef struct packed {
        logic                       third;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
    } pkt_t;

endpackage

/* rtl/psmt_decode.sv */
// Packet alignment and delta extraction for the PS/2 mouse packet tracker.
// Depends on psmt_pkg.
module psmt_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_accept,
    input  logic [psmt_pkg::BYTE_W-1:0]   byte_data,
    output psmt_pkg::pkt_t                pkt
);
    import psmt_pkg::*;

    idx_t              idx_reg;
    idx_t              idx_next;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] first_next;
    logic [BYTE_W-1:0] second_reg;
    logic [BYTE_W-1:0] second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= IDX_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            idx_reg    <= idx_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Next state: a first byte is taken only when its sync bit is set.
    always_comb begin
        idx_next    = idx_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (byte_accept) begin
            unique case (idx_reg)
                IDX_SECOND: begin
                    second_next = byte_data;
                    idx_next    = IDX_THIRD;
                end
                IDX_THIRD: begin
                    idx_next = IDX_FIRST;
                end
                default: begin
                    if (byte_data[SYNC_BIT]) begin
                        first_next = byte_data;
                        idx_next   = IDX_SECOND;
                    end else begin
                        idx_next = IDX_FIRST;
                    end
                end
            endcase
        end
    end

    // Outputs: the deltas are nine-bit two's complement values.
    always_comb begin
        pkt.third = (idx_reg == IDX_THIRD);
        pkt.dx    = $signed({first_reg[XSIGN_BIT], second_reg});
        pkt.dy    = $signed({first_reg[YSIGN_BIT], byte_data});
    end

endmodule

/* rtl/psmt_update.sv */
// Saturating pointer position update for the PS/2 mouse packet tracker.
// Depends on psmt_pkg.
module psmt_update #(
    parameter int POSITION_WIDTH = psmt_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  update_en,
    input  logic signed [psmt_pkg::DELTA_W-1:0]   dx,
    input  logic signed [psmt_pkg::DELTA_W-1:0]   dy,
    input  logic [psmt_pkg::COORD_W-1:0]          max_x,
    input  logic [psmt_pkg::COORD_W-1:0]          max_y,
    output logic [POSITION_WIDTH-1:0]             pos_x,
    output logic [POSITION_WIDTH-1:0]             pos_y
);
    import psmt_pkg::*;

    // Working width holds position, limit and a nine-bit delta with sign.
    localparam int SW = ((POSITION_WIDTH > COORD_W) ? POSITION_WIDTH : COORD_W) + 2;

    logic [POSITION_WIDTH-1:0] pos_x_reg;
    logic [POSITION_WIDTH-1:0] pos_x_next;
    logic [POSITION_WIDTH-1:0] pos_y_reg;
    logic [POSITION_WIDTH-1:0] pos_y_next;

    // The effective limit is the register value, capped by what the
    // position register can hold. The sum is clamped to [0, limit].
    function automatic logic [POSITION_WIDTH-1:0] sat_add(
        input logic [POSITION_WIDTH-1:0] pos,
        input logic signed [SW-1:0]      delta,
        input logic [COORD_W-1:0]        max_val
    );
        logic [SW-1:0]        cap;
        logic [SW-1:0]        lim;
        logic signed [SW-1:0] sum;
        cap = SW'({POSITION_WIDTH{1'b1}});
        lim = (SW'(max_val) < cap) ? SW'(max_val) : cap;
        sum = $signed(SW'(pos)) + delta;
        if (sum < 0) begin
            return '0;
        end else if ($unsigned(sum) > lim) begin
            return POSITION_WIDTH'(lim);
        end else begin
            return POSITION_WIDTH'($unsigned(sum));
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= POSITION_WIDTH'(RESET_POS_X);
            pos_y_reg <= POSITION_WIDTH'(RESET_POS_Y);
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (update_en) begin
            // Y grows downward on screen, so the mouse Y delta is subtracted.
            pos_x_next = sat_add(pos_x_reg, SW'(dx), max_x);
            pos_y_next = sat_add(pos_y_reg, -SW'(dy), max_y);
        end
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;

endmodule

/* rtl/ps2_mouse_packet_tracker_top.sv */
// Top level of the PS/2 mouse packet tracker: channels, configuration registers.
// Depends on psmt_pkg, psmt_decode and psmt_update.
//
//   Channel   Direction  Payload                           Handshake
//   s_        in         mouse_byte (one raw mouse byte)   s_tvalid / s_tready
//   m_        out        pointer_x, pointer_y              m_tvalid / m_tready
//   cfg_      in         max_x (index 0), max_y (index 1)  cfg_wr_en, no stall
//
// A packet of three bytes yields one item on the cycle after its third byte
// is accepted. The position registers are the output payload and the only
// thing that holds m_tdata, so first and second bytes keep flowing while a
// result waits; only a third byte stalls, and only while the previous result
// is still held and m_tready is low.
// Reset (aresetn low, synchronous) recenters the pointer to 512/384, sets the
// limits to 1023/767 and realigns to the start of a packet.
module ps2_mouse_packet_tracker_top #(
    parameter int POSITION_WIDTH = psmt_pkg::POSITION_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input byte stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] mouse_byte
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [15:0] pointer_x, [31:16] pointer_y
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [psmt_pkg::COORD_W-1:0]    cfg_data
);
    import psmt_pkg::*;

    logic [COORD_W-1:0]        max_x_reg;
    logic [COORD_W-1:0]        max_x_next;
    logic [COORD_W-1:0]        max_y_reg;
    logic [COORD_W-1:0]        max_y_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      s_accept;
    logic                      pkt_done;
    pkt_t                      pkt;
    logic [POSITION_WIDTH-1:0] pos_x;
    logic [POSITION_WIDTH-1:0] pos_y;

    // Configuration registers: written directly, the index picks the target.
    always_comb begin
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_X: max_x_next = cfg_data;
                REG_MAX_Y: max_y_next = cfg_data;
            endcase
        end
    end

    // A third byte may enter only when the result slot is free or being
    // drained this cycle, since it overwrites the positions on m_tdata.
    assign s_tready = !pkt.third || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign pkt_done = s_accept && pkt.third;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pkt_done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_x_reg   <= COORD_W'(MAX_X_RESET);
            max_y_reg   <= COORD_W'(MAX_Y_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            max_x_reg   <= max_x_next;
            max_y_reg   <= max_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    psmt_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .byte_data   (s_tdata),
        .pkt         (pkt)
    );

    psmt_update #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (pkt_done),
        .dx        (pkt.dx),
        .dy        (pkt.dy),
        .max_x     (max_x_reg),
        .max_y     (max_y_reg),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    // Positions are reported as 16-bit coordinates.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {COORD_W'(pos_y), COORD_W'(pos_x)};

endmodule

/* tb/tb.sv */
// Self-checking testbench for ps2_mouse_packet_tracker_top: byte stream in, pointer stream out.
// Depends on psmt_pkg (types, bit positions, register indexes) and the RTL top level.
// Checks each output item against an in-bench pointer tracker, with random gaps and stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psmt_pkg::*;

    // The run is short; this bound leaves a wide margin even with every stall at its longest.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_GAP   = 4;
    localparam int END_CYCLES   = 10;

    // Expected contents of one output item, laid out like m_tdata.
    typedef struct packed {
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] px;
    } pointer_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;
    logic               cfg_wr_en;
    logic               cfg_addr;
    logic [COORD_W-1:0] cfg_data;

    // Pointer tracker state, mirroring the block after reset.
    idx_t               trk_idx    = IDX_FIRST;
    logic [7:0]         trk_first  = '0;
    logic [7:0]         trk_second = '0;
    logic [COORD_W-1:0] trk_x      = COORD_W'(RESET_POS_X);
    logic [COORD_W-1:0] trk_y      = COORD_W'(RESET_POS_Y);
    logic [COORD_W-1:0] lim_x      = COORD_W'(MAX_X_RESET);
    logic [COORD_W-1:0] lim_y      = COORD_W'(MAX_Y_RESET);

    // Pointer positions still owed by the block, oldest first.
    pointer_t pending_pointers[$];

    int  err_count   = 0;
    int  cycle_count = 0;
    // When calm is set, neither side inserts random gaps or stalls; a requested hold-off still applies.
    bit  calm        = 1'b0;
    // A request from a test for one long receiver hold-off; the receiver marks it as taken.
    bit  hold_req    = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_left   = 0;
    int  stall_left  = 0;

    ps2_mouse_packet_tracker_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Advance the pointer tracker by one accepted byte. Returns 1 when the byte completes a
    // packet, with the new positions in pos.
    function automatic bit track_byte(input logic [7:0] b, output pointer_t pos);
        int dx;
        int dy;
        int nx;
        int ny;
        track_byte = 1'b0;
        pos        = '0;
        case (trk_idx)
            IDX_SECOND: begin
                trk_second = b;
                trk_idx    = IDX_THIRD;
            end
            IDX_THIRD: begin
                trk_idx = IDX_FIRST;
                // 9-bit deltas: the low eight bits come from the data byte, the sign from
                // the first byte of the packet.
                dx = int'(trk_second) - (trk_first[XSIGN_BIT] ? 256 : 0);
                dy = int'(b) - (trk_first[YSIGN_BIT] ? 256 : 0);
                nx = int'(trk_x) + dx;
                ny = int'(trk_y) - dy;
                // Saturate at both ends. A position already above a lowered limit is pulled
                // down to it here, unless the delta alone brings it within the limit.
                if (nx < 0) nx = 0;
                else if (nx > int'(lim_x)) nx = int'(lim_x);
                if (ny < 0) ny = 0;
                else if (ny > int'(lim_y)) ny = int'(lim_y);
                trk_x      = COORD_W'(nx);
                trk_y      = COORD_W'(ny);
                pos.px     = trk_x;
                pos.py     = trk_y;
                track_byte = 1'b1;
            end
            default: begin
                // Only a byte with the sync bit set may open a packet; others are dropped.
                if (b[SYNC_BIT]) begin
                    trk_first = b;
                    trk_idx   = IDX_SECOND;
                end else begin
                    trk_idx = IDX_FIRST;
                end
            end
        endcase
    endfunction

    // Sender gaps: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver side. A long hold-off, when a test asks for one, is counted down here; otherwise
    // m_tready follows a random pattern of short and occasional long stalls.
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (calm) begin
            m_tready = 1'b1;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready = 1'b1;
            end else begin
                m_tready   = 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // Output checker: every accepted output item is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pointers.size() == 0) begin
                err_count++;
                $display("%0t: unexpected item x=%0d y=%0d", $time,
                         m_tdata[15:0], m_tdata[31:16]);
            end else begin
                pointer_t want;
                want = pending_pointers.pop_front();
                if (m_tdata[15:0] !== want.px) begin
                    err_count++;
                    $display("%0t: pointer_x expected %0d, got %0d", $time,
                             want.px, m_tdata[15:0]);
                end
                if (m_tdata[31:16] !== want.py) begin
                    err_count++;
                    $display("%0t: pointer_y expected %0d, got %0d", $time,
                             want.py, m_tdata[31:16]);
                end
            end
        end
    end

    // Offer one mouse byte, hold it until accepted, then update the tracker.
    task automatic send_byte(input logic [7:0] b);
        int       gap;
        pointer_t pos;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        if (track_byte(b, pos)) pending_pointers.push_back(pos);
    endtask

    // Stop offering and wait until every owed item has come out, then let the block settle
    // so it is quiet before a register write.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_pointers.size() != 0) @(posedge aclk);
        repeat (SETTLE_GAP) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic idx, input logic [COORD_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_data  = value;
        if (idx == REG_MAX_X) lim_x = value;
        else lim_y = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_limits(input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my);
        wait_idle();
        cfg_write(REG_MAX_X, mx);
        cfg_write(REG_MAX_Y, my);
    endtask

    // One well-formed packet with random content. With upward set, both deltas push the
    // pointer toward the upper limits (x grows, y grows since y moves screen downward).
    task automatic send_packet(input bit upward);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        b0           = $urandom;
        b1           = $urandom;
        b2           = $urandom;
        b0[SYNC_BIT] = 1'b1;
        if (upward) begin
            b0[XSIGN_BIT] = 1'b0;
            b1[7]         = 1'b1;
            b0[YSIGN_BIT] = 1'b1;
            b2[7]         = 1'b0;
        end
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
    endtask

    // One or two raw bytes: they may be dropped, or open a packet out of step.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 2);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Bytes with the sync bit clear are dropped while aligning; then a null packet shows the
    // reset center.
    task automatic test_alignment();
        send_byte(8'h00);
        send_byte(8'hF7);
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Largest and smallest deltas on the X axis, with sign bits in every combination, and
    // data bytes whose sync bit is clear or set.
    task automatic test_delta_extremes();
        send_byte(8'h08); send_byte(8'h7F); send_byte(8'h80);
        send_byte(8'h38); send_byte(8'h80); send_byte(8'h7F);
        send_byte(8'h18); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h28); send_byte(8'hFF); send_byte(8'h01);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    endtask

    // Lowering the limits below the current position clamps it on the next packet, even
    // with a zero delta; a limit of zero pins the pointer at the origin.
    task automatic test_clamp_after_lowering();
        set_limits(16'd100, 16'd50);
        send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
        set_limits(16'd0, 16'd0);
        send_byte(8'hC8); send_byte(8'h05); send_byte(8'hF0);
    endtask

    // Mostly well-formed packets, the rest noise and broken packets.
    task automatic test_random_walk(input int packets, input bit upward_bias, input bit quiet);
        calm = quiet;
        repeat (packets) begin
            if ($urandom_range(0, 99) < 85) send_packet(upward_bias && ($urandom_range(0, 3) != 0));
            else send_noise();
        end
        calm = 1'b0;
    endtask

    // The receiver holds off for a long stretch while bytes keep coming back to back, so a
    // third byte finds the output still occupied and the input stalls.
    task automatic test_backpressure();
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (15) send_packet(1'b0);
        calm     = 1'b0;
    endtask

    // The sender stops in the middle of a packet until the output has drained completely,
    // then finishes that packet and carries on.
    task automatic test_drain_pause();
        logic [7:0] b0;
        repeat (10) send_packet(1'b0);
        b0           = $urandom;
        b0[SYNC_BIT] = 1'b1;
        send_byte(b0);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_pointers.size() != 0) @(posedge aclk);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        repeat (10) send_packet(1'b0);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_MAX_X;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, starting from the reset limits and center.
        test_alignment();
        test_delta_extremes();
        test_clamp_after_lowering();

        // Random part across several limit settings, both extremes included.
        set_limits(16'(MAX_X_RESET), 16'(MAX_Y_RESET));
        test_random_walk(50, 1'b0, 1'b0);
        set_limits(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
        test_random_walk(40, 1'b0, 1'b1);
        test_backpressure();
        test_drain_pause();
        set_limits(16'hFFFF, 16'hFFFF);
        test_random_walk(30, 1'b1, 1'b0);
        set_limits(16'hFFFF, 16'($urandom_range(0, 40)));
        test_random_walk(25, 1'b0, 1'b0);

        // Drain, give stray items a chance to show up, then report.
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_pointers.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
